@@ rtl/vbs_pkg.sv @@
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared constants, types and a helper function of the background subtractor.
// ----------------------------------------------------------------------------
package vbs_pkg;

    localparam int NUM_SAMPLES = 20;
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 8;
    localparam int SLOT_IN_W = 5;
    localparam int SLOT_W  = $clog2(NUM_SAMPLES);
    localparam int X_W     = $clog2(MAX_WIDTH);
    localparam int Y_W     = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = X_W + Y_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CNT_W   = $clog2(NUM_SAMPLES + 1);
    localparam int DRAW_W  = 16;
    localparam int UF_W    = 9;
    localparam int SIZE_W  = 9;
    localparam int THR_W   = 8;
    localparam int MIN_W   = 5;

    // register indexes
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_MIN       = 3'd1;
    localparam logic [2:0] REG_UPDATE    = 3'd2;
    localparam logic [2:0] REG_WIDTH     = 3'd3;
    localparam logic [2:0] REG_HEIGHT    = 3'd4;

    // actions
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    typedef logic [NUM_SAMPLES-1:0][PIX_W-1:0] t_sample_word;

    // step of each direction on one axis: 01 forward, 11 backward, 00 none
    localparam logic [7:0][1:0] STEP_DX = {2'b01, 2'b00, 2'b11, 2'b11,
                                           2'b11, 2'b00, 2'b01, 2'b01};
    localparam logic [7:0][1:0] STEP_DY = {2'b11, 2'b11, 2'b11, 2'b00,
                                           2'b01, 2'b01, 2'b01, 2'b00};

    // slot index taken modulo the sample count, as a small table
    function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_IN_W-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = 0; i < 2**SLOT_IN_W; i++) begin
            if (v == SLOT_IN_W'(i)) begin
                r = SLOT_W'(i % NUM_SAMPLES);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/vibe_background_subtractor.sv @@
// Load word: written in S_WOWN, result registered on leaving S_OUT. Classify
// word: S_READ, S_CMP, S_CNT, S_WAIT until the 16-step serial remainder of the
// update draw is done, then S_WOWN, S_WNBR, S_OUT. A new word is taken only in
// S_IDLE. A waiting result stalls the input only once the following word is done.
// Reset (synchronous, active low) restores register defaults and control state;
// the sample store is not cleared and must be loaded before it is classified.
// ----------------------------------------------------------------------------
// vibe_background_subtractor
// Per-pixel background model: sample load, classify and random model update.
// ----------------------------------------------------------------------------
module vibe_background_subtractor import vbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [PIX_W-1:0]     i_pixel_value,
    input  logic [SLOT_IN_W-1:0] i_own_slot,
    input  logic [SLOT_IN_W-1:0] i_neighbour_slot,
    input  logic [2:0]           i_direction,
    input  logic [DRAW_W-1:0]    i_update_draw,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_is_foreground,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_CNT  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_WOWN = 3'd5;
    localparam logic [2:0] S_WNBR = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration registers
    logic [THR_W-1:0]  r_thr;
    logic [MIN_W-1:0]  r_min;
    logic [UF_W-1:0]   r_uf;
    logic [SIZE_W-1:0] r_fw;
    logic [SIZE_W-1:0] r_fh;
    logic [2:0]        reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(20);
            r_min <= MIN_W'(2);
            r_uf  <= UF_W'(16);
            r_fw  <= SIZE_W'(256);
            r_fh  <= SIZE_W'(256);
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_THRESHOLD: r_thr <= pwdata[THR_W-1:0];
                REG_MIN:       r_min <= pwdata[MIN_W-1:0];
                REG_UPDATE:    r_uf  <= pwdata[UF_W-1:0];
                REG_WIDTH:     r_fw  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:    r_fh  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = 32'(r_thr);
            REG_MIN:       prdata = 32'(r_min);
            REG_UPDATE:    prdata = 32'(r_uf);
            REG_WIDTH:     prdata = 32'(r_fw);
            REG_HEIGHT:    prdata = 32'(r_fh);
            default:       prdata = '0;
        endcase
    end

    // effective sizes and factor
    logic [UF_W-1:0] uf_eff;
    logic [12:0]     ew, eh;
    assign uf_eff = (r_uf == '0) ? UF_W'(1) : r_uf;
    always_comb begin
        if (r_fw == '0)                 ew = 13'd1;
        else if (13'(r_fw) > 13'(MAX_WIDTH)) ew = 13'(MAX_WIDTH);
        else                            ew = 13'(r_fw);
        if (r_fh == '0)                 eh = 13'd1;
        else if (13'(r_fh) > 13'(MAX_HEIGHT)) eh = 13'(MAX_HEIGHT);
        else                            eh = 13'(r_fh);
    end

    // control and latched word
    logic [2:0]              r_state, n_state;
    logic                    r_act;
    logic [X_W-1:0]          r_x;
    logic [Y_W-1:0]          r_y;
    logic [PIX_W-1:0]        r_pix;
    logic [SLOT_W-1:0]       r_own, r_nbr;
    logic [2:0]              r_dir;
    logic [NUM_SAMPLES-1:0]  r_match;
    logic                    r_bg;
    logic                    r_out_valid;
    logic                    r_fg;
    logic                    accept;
    logic [X_W-1:0]          x_sat;
    logic [Y_W-1:0]          y_sat;
    t_sample_word            rd_data;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (13'(i_pos_x) >= 13'(MAX_WIDTH))  x_sat = X_W'(MAX_WIDTH - 1);
        else                                 x_sat = X_W'(i_pos_x);
        if (13'(i_pos_y) >= 13'(MAX_HEIGHT)) y_sat = Y_W'(MAX_HEIGHT - 1);
        else                                 y_sat = Y_W'(i_pos_y);
    end

    // remainder of the update draw
    logic div_done, div_zero;
    vbs_remainder u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_draw    (i_update_draw),
        .i_divisor (uf_eff),
        .o_done    (div_done),
        .o_zero    (div_zero)
    );

    // neighbour location
    logic [X_W-1:0] nx;
    logic [Y_W-1:0] ny;
    always_comb begin
        nx = r_x;
        ny = r_y;
        if (STEP_DX[r_dir] == 2'b01) begin
            if (13'(r_x) + 13'd1 < ew) nx = r_x + X_W'(1);
        end else if (STEP_DX[r_dir] == 2'b11) begin
            if (r_x != '0) nx = r_x - X_W'(1);
        end
        if (STEP_DY[r_dir] == 2'b01) begin
            if (13'(r_y) + 13'd1 < eh) ny = r_y + Y_W'(1);
        end else if (STEP_DY[r_dir] == 2'b11) begin
            if (r_y != '0) ny = r_y - Y_W'(1);
        end
    end

    // sample store port control
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SLOT_W-1:0]   wr_slot;
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_y, r_x};
        wr_slot = r_own;
        if (r_state == S_WOWN) begin
            wr_en = (r_act == ACT_LOAD) || (r_bg && div_zero);
        end else if (r_state == S_WNBR) begin
            wr_en   = r_bg && div_zero;
            wr_addr = {ny, nx};
            wr_slot = r_nbr;
        end
    end

    vbs_sample_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr ({r_y, r_x}),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_slot (wr_slot),
        .i_wr_data (r_pix)
    );

    // per-sample match flags
    logic [NUM_SAMPLES-1:0] match;
    logic [PIX_W-1:0]       diff;
    always_comb begin
        diff = '0;
        for (int t = 0; t < NUM_SAMPLES; t++) begin
            diff = (r_pix >= rd_data[t]) ? (r_pix - rd_data[t]) : (rd_data[t] - r_pix);
            match[t] = (diff < r_thr);
        end
    end

    // match count
    logic [CNT_W-1:0] count;
    always_comb begin
        count = '0;
        for (int t = 0; t < NUM_SAMPLES; t++) begin
            count = count + CNT_W'(r_match[t]);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = (i_action == ACT_LOAD) ? S_WOWN : S_READ;
            S_READ: n_state = S_CMP;
            S_CMP:  n_state = S_CNT;
            S_CNT:  n_state = S_WAIT;
            S_WAIT: if (div_done) n_state = S_WOWN;
            S_WOWN: n_state = (r_act == ACT_LOAD) ? S_OUT : S_WNBR;
            S_WNBR: n_state = S_OUT;
            S_OUT:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_x   <= x_sat;
            r_y   <= y_sat;
            r_pix <= i_pixel_value;
            r_own <= slot_mod(i_own_slot);
            r_nbr <= slot_mod(i_neighbour_slot);
            r_dir <= i_direction;
            r_bg  <= 1'b0;
        end
        if (r_state == S_CMP) begin
            r_match <= match;
        end
        if (r_state == S_CNT) begin
            r_bg <= (6'(count) >= 6'(r_min));
        end
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_fg <= (r_act == ACT_CLASSIFY) && !r_bg;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_foreground = r_fg;

endmodule

@@ rtl/vbs_sample_ram.sv @@
// ----------------------------------------------------------------------------
// vbs_sample_ram
// Sample store: one word per pixel location, one byte lane per sample slot.
// ----------------------------------------------------------------------------
module vbs_sample_ram import vbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output t_sample_word         o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [SLOT_W-1:0]    i_wr_slot,
    input  logic [PIX_W-1:0]     i_wr_data
);

    t_sample_word r_mem [DEPTH];
    t_sample_word r_rd_data;

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // single slot write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_slot] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/vbs_remainder.sv @@
// ----------------------------------------------------------------------------
// vbs_remainder
// Bit-serial remainder of the update draw by the update factor.
// ----------------------------------------------------------------------------
module vbs_remainder import vbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DRAW_W-1:0] i_draw,
    input  logic [UF_W-1:0]   i_divisor,
    output logic              o_done,
    output logic              o_zero
);

    localparam int STEP_W = $clog2(DRAW_W + 1);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DRAW_W-1:0] r_shift, n_shift;
    logic [UF_W-1:0]   r_rem, n_rem;
    logic [UF_W-1:0]   r_div, n_div;
    logic [UF_W:0]     trial;

    // one quotient bit per cycle
    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_div   = r_div;
        trial   = {r_rem, r_shift[DRAW_W-1]};
        if (i_start) begin
            n_busy  = 1'b1;
            n_step  = '0;
            n_shift = i_draw;
            n_rem   = '0;
            n_div   = i_divisor;
        end else if (r_busy) begin
            n_shift = {r_shift[DRAW_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem = UF_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = UF_W'(trial);
            end
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(DRAW_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_div   <= n_div;
    end

    assign o_done = !r_busy && !i_start;
    assign o_zero = (r_rem == '0);

endmodule
